FILE: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and codes for the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W  = 31;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 11;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2,
    MARK_RSVD    = 2'd3
  } mark_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;  // write empty mark at clear pointer
    logic load;        // capture item
    logic hash;        // set probe at home slot
    logic read;        // issue memory read at probe slot
    logic eval;        // judge read data, act, step probe
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic finished;    // eval finished this item
  } stat_t;

endpackage

FILE: src/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface lpht_if #(
  parameter int W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// sequencer: clear sweep, then hash and read/eval probe loop per item
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lpht_pkg::stat_t stat,
  output lpht_pkg::cmd_t  cmd
);

  lpht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lpht_pkg::S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::S_CLEAR: if (stat.clear_done) state_nxt = lpht_pkg::S_IDLE;
      lpht_pkg::S_IDLE:  if (in_valid) state_nxt = lpht_pkg::S_HASH;
      lpht_pkg::S_HASH:  state_nxt = lpht_pkg::S_READ;
      lpht_pkg::S_READ:  state_nxt = lpht_pkg::S_EVAL;
      lpht_pkg::S_EVAL:  state_nxt = stat.finished ? lpht_pkg::S_OUT : lpht_pkg::S_READ;
      lpht_pkg::S_OUT:   if (out_ready) state_nxt = lpht_pkg::S_IDLE;
      default:           state_nxt = lpht_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      lpht_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      lpht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lpht_pkg::S_HASH:  cmd.hash = 1'b1;
      lpht_pkg::S_READ:  cmd.read = 1'b1;
      lpht_pkg::S_EVAL:  cmd.eval = 1'b1;
      lpht_pkg::S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: src/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// slot memories, probe pointer, live count and result registers
// ----------------------------------------------------------------------------
module lpht_dp #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpht_pkg::cmd_t               cmd,
  output lpht_pkg::stat_t              stat,
  input  logic [lpht_pkg::MODE_W-1:0]  in_mode,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0]       in_value_in,
  output logic [lpht_pkg::STAT_W-1:0]  out_status,
  output logic [VALUE_WIDTH-1:0]       out_value_out,
  output logic [lpht_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [lpht_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [VALUE_WIDTH-1:0]     val_mem [SLOTS];
  logic [1:0]                 mark_mem [SLOTS];

  logic [lpht_pkg::KEY_W-1:0] rd_key_r;
  logic [VALUE_WIDTH-1:0]     rd_val_r;
  lpht_pkg::mark_t            rd_mark_r;

  lpht_pkg::mode_t            mode_r;
  logic [lpht_pkg::KEY_W-1:0] key_r;
  logic [VALUE_WIDTH-1:0]     vin_r;
  logic [AW-1:0]              probe_r, clr_r;
  logic [CW-1:0]              steps_r;   // probes done this item
  logic [CW-1:0]              live_r;
  logic [lpht_pkg::STAT_W-1:0] status_r;
  logic [VALUE_WIDTH-1:0]     vout_r;

  logic [AW-1:0] home, probe_next;
  logic          is_live, hit, last_probe;
  logic          wr_en;
  logic [1:0]    wr_mark;
  logic [AW-1:0] wr_addr;

  // home slot: key mod SLOTS, power of two is a mask
  if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
    assign home = key_r[AW-1:0];
  end else begin : g_mod
    // quotient by reciprocal multiply on the load cycle, remainder on the hash cycle
    localparam int QW = 32 - AW;
    localparam longint unsigned RECIP =
      ((64'd1 << (lpht_pkg::KEY_W + AW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [31:0] RECIP_C = 32'(RECIP);
    logic [62:0]                prod;
    logic [QW-1:0]              quo_r;
    logic [lpht_pkg::KEY_W-1:0] rem;
    assign prod = 63'(in_key) * 63'(RECIP_C);
    always_ff @(posedge clk) begin
      if (cmd.load) quo_r <= prod[62:lpht_pkg::KEY_W+AW];
    end
    assign rem  = key_r - lpht_pkg::KEY_W'(quo_r) * lpht_pkg::KEY_W'(SLOTS);
    assign home = rem[AW-1:0];
  end

  assign probe_next = (32'(probe_r) + 32'd1 >= 32'(SLOTS)) ? '0 : probe_r + AW'(1);
  assign is_live    = (rd_mark_r == lpht_pkg::MARK_LIVE);
  assign hit        = is_live && (rd_key_r == key_r);
  assign last_probe = (32'(steps_r) + 32'd1 >= 32'(SLOTS));

  always_comb begin
    stat.clear_done = (32'(clr_r) == SLOTS - 1);
    stat.finished   = 1'b1;
    wr_en   = 1'b0;
    wr_mark = lpht_pkg::MARK_EMPTY;
    wr_addr = probe_r;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
    end else if (cmd.eval) begin
      case (mode_r) inside
        lpht_pkg::MODE_INSERT: begin
          if (32'(live_r) >= 32'(SLOTS)) stat.finished = 1'b1;
          else if (!is_live) begin
            wr_en   = 1'b1;
            wr_mark = lpht_pkg::MARK_LIVE;
          end else stat.finished = last_probe;
        end
        lpht_pkg::MODE_REMOVE, lpht_pkg::MODE_SEARCH: begin
          if (rd_mark_r == lpht_pkg::MARK_EMPTY) stat.finished = 1'b1;
          else if (hit) begin
            stat.finished = 1'b1;
            if (mode_r == lpht_pkg::MODE_REMOVE) begin
              wr_en   = 1'b1;
              wr_mark = lpht_pkg::MARK_DELETED;
            end
          end else stat.finished = last_probe;
        end
        default: stat.finished = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mark_mem[wr_addr] <= wr_mark;
    if (cmd.eval && mode_r == lpht_pkg::MODE_INSERT && wr_en) begin
      key_mem[probe_r] <= key_r;
      val_mem[probe_r] <= vin_r;
    end
    if (cmd.read) begin
      rd_mark_r <= lpht_pkg::mark_t'(mark_mem[probe_r]);
      rd_key_r  <= key_mem[probe_r];
      rd_val_r  <= val_mem[probe_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      live_r <= '0;
    end else begin
      if (cmd.clear_step && !stat.clear_done) clr_r <= clr_r + AW'(1);
      if (cmd.eval && wr_en) begin
        if (mode_r == lpht_pkg::MODE_INSERT) live_r <= live_r + CW'(1);
        else if (live_r != '0)               live_r <= live_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= lpht_pkg::mode_t'(in_mode);
      key_r    <= in_key;
      vin_r    <= in_value_in;
      steps_r  <= '0;
      status_r <= lpht_pkg::ST_MISSING;
      vout_r   <= '0;
    end else if (cmd.hash) begin
      probe_r <= home;
    end else if (cmd.eval) begin
      probe_r <= probe_next;
      steps_r <= steps_r + CW'(1);
      case (mode_r) inside
        lpht_pkg::MODE_INSERT:
          status_r <= wr_en ? lpht_pkg::ST_DONE : lpht_pkg::ST_FULL;
        lpht_pkg::MODE_REMOVE, lpht_pkg::MODE_SEARCH:
          if (hit && rd_mark_r != lpht_pkg::MARK_EMPTY) begin
            status_r <= lpht_pkg::ST_DONE;
            if (mode_r == lpht_pkg::MODE_SEARCH) vout_r <= rd_val_r;
          end
        default: ;
      endcase
    end
  end

  assign out_status    = status_r;
  assign out_value_out = vout_r;
  assign out_occupancy = lpht_pkg::OCC_W'(live_r);

endmodule

FILE: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressing key/value table with linear probing and deleted marks
// ----------------------------------------------------------------------------
// sequence: accept, set the probe at the home slot, then read and evaluate per
//   probe, for 1 to SLOTS probes, then the result is held until taken,
//   after which the next item is accepted
// throughput: one item at a time; each probe is one mark/key/value memory read
//   followed by an evaluate step on the registered read data
// reset: synchronous, active low; a clearing pass marks every slot empty,
//   during which no item is accepted
module linear_probe_hash_table #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic   clk,
  input logic   rst_n,
  lpht_if.sink   in_ch,
  lpht_if.source out_ch
);

  lpht_pkg::cmd_t  cmd;
  lpht_pkg::stat_t stat;

  // input payload: {mode, key, value_in}
  logic [lpht_pkg::MODE_W-1:0] in_mode;
  logic [lpht_pkg::KEY_W-1:0]  in_key;
  logic [VALUE_WIDTH-1:0]      in_value_in;
  assign {in_mode, in_key, in_value_in} = in_ch.data;

  // result payload: {status, value_out, occupancy}
  logic [lpht_pkg::STAT_W-1:0] out_status;
  logic [VALUE_WIDTH-1:0]      out_value_out;
  logic [lpht_pkg::OCC_W-1:0]  out_occupancy;
  assign out_ch.data = {out_status, out_value_out, out_occupancy};

  // sequencer
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot storage and probe datapath
  lpht_dp #(
    .SLOTS       (SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_value_in   (in_value_in),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_occupancy (out_occupancy)
  );

  // never ready for an item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while result pending");

  // at most one command active at a time
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.load, cmd.hash, cmd.read, cmd.eval}))
    else $error("overlapping datapath commands");

  // a read is always followed by an evaluate
  a_rd_ev: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |=> cmd.eval)
    else $error("read not followed by evaluate");

  // a miss or a full table reports zero value
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_status != lpht_pkg::ST_DONE |-> out_value_out == '0)
    else $error("nonzero value on miss");

endmodule

FILE: tb/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// drives insert, remove and search requests into the probing table and
// compares each reply against a software copy of the slot array
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;

  localparam int SLOTS     = 1024;
  localparam int VAL_W     = 32;
  localparam int KEY_W     = lpht_pkg::KEY_W;
  localparam int OCC_W     = lpht_pkg::OCC_W;
  localparam int STAT_W    = lpht_pkg::STAT_W;
  localparam int REQ_W     = lpht_pkg::MODE_W + KEY_W + VAL_W;
  localparam int RSP_W     = STAT_W + VAL_W + OCC_W;
  localparam int CYC_LIMIT = 20000000;
  localparam int RAND_ITEMS_PER_PHASE = 160;

  typedef struct {
    lpht_pkg::status_t st;
    logic [VAL_W-1:0]  val;
    logic [OCC_W-1:0]  occ;
  } reply_t;

  // scoreboard: keeps its own slot array and predicts each reply on acceptance
  class table_scoreboard;
    lpht_pkg::mark_t  marks [SLOTS];
    logic [KEY_W-1:0] keys  [SLOTS];
    logic [VAL_W-1:0] vals  [SLOTS];
    int               live;
    reply_t           pending_replies [$];

    function new();
      foreach (marks[i]) marks[i] = lpht_pkg::MARK_EMPTY;
      live = 0;
    endfunction

    // live slot holding k on the probe chain, or -1
    function int locate(logic [KEY_W-1:0] k);
      int s;
      s = k % SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (marks[s] == lpht_pkg::MARK_EMPTY) return -1;
        if (marks[s] == lpht_pkg::MARK_LIVE && keys[s] == k) return s;
        s = (s + 1) % SLOTS;
      end
      return -1;
    endfunction

    function void note_request(lpht_pkg::mode_t m, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v);
      reply_t r;
      int     s;
      r.st  = lpht_pkg::ST_MISSING;
      r.val = '0;
      case (m)
        lpht_pkg::MODE_INSERT: begin
          r.st = lpht_pkg::ST_FULL;
          if (live < SLOTS) begin
            s = k % SLOTS;
            for (int n = 0; n < SLOTS; n++) begin
              if (marks[s] != lpht_pkg::MARK_LIVE) begin
                keys[s]  = k;
                vals[s]  = v;
                marks[s] = lpht_pkg::MARK_LIVE;
                live++;
                r.st = lpht_pkg::ST_DONE;
                break;
              end
              s = (s + 1) % SLOTS;
            end
          end
        end
        lpht_pkg::MODE_REMOVE: begin
          s = locate(k);
          if (s >= 0) begin
            marks[s] = lpht_pkg::MARK_DELETED;
            if (live > 0) live--;
            r.st = lpht_pkg::ST_DONE;
          end
        end
        lpht_pkg::MODE_SEARCH: begin
          s = locate(k);
          if (s >= 0) begin
            r.val = vals[s];
            r.st  = lpht_pkg::ST_DONE;
          end
        end
        default: ;
      endcase
      r.occ = live[OCC_W-1:0];
      pending_replies.push_back(r);
    endfunction

    // empty string when the reply matches the oldest prediction
    function string check_reply(logic [RSP_W-1:0] d);
      reply_t           e;
      logic [STAT_W-1:0] st;
      logic [VAL_W-1:0]  v;
      logic [OCC_W-1:0]  o;
      string             msg;
      {st, v, o} = d;
      if (pending_replies.size() == 0) return "reply with no request outstanding";
      e   = pending_replies.pop_front();
      msg = "";
      if (st !== e.st) msg = {msg, $sformatf(" status %0d exp %0d", st, e.st)};
      if (v !== e.val) msg = {msg, $sformatf(" value %h exp %h", v, e.val)};
      if (o !== e.occ) msg = {msg, $sformatf(" occupancy %0d exp %0d", o, e.occ)};
      return msg;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   errors   = 0;
  int   cycles   = 0;
  int   idle_pct = 0;   // chance the sender leaves a gap before an item
  int   stall_pct = 0;  // chance the receiver holds ready low in a cycle

  table_scoreboard sb = new();

  lpht_if #(.W(REQ_W)) in_ch ();
  lpht_if #(.W(RSP_W)) out_ch ();

  linear_probe_hash_table #(
    .SLOTS       (SLOTS),
    .VALUE_WIDTH (VAL_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // watchdog, also covers the slot clearing pass after reset
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("[linear_probe_hash_table] ERROR");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d:%s", cycles, msg);
    errors++;
  endtask

  // receiver: check on handshake with sampled values, then pick next ready
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      msg = sb.check_reply(out_ch.data);
      if (msg != "") report(msg);
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // valid stays high across back-to-back items, dropped only for a gap
  task automatic send_item(lpht_pkg::mode_t m, logic [KEY_W-1:0] k,
                           logic [VAL_W-1:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {m, k, v};
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(m, k, v);
  endtask

  // mostly keys that crowd a few home slots so chains and hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85)
      return KEY_W'($urandom_range(0, 15) + SLOTS * $urandom_range(0, 5));
    return KEY_W'($urandom() & 32'h7fff_ffff);
  endfunction

  task automatic random_phase(int gap, int stall);
    int r;
    idle_pct  = gap;
    stall_pct = stall;
    for (int i = 0; i < RAND_ITEMS_PER_PHASE; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      send_item(lpht_pkg::MODE_INSERT, pick_key(), $urandom());
      else if (r < 65) send_item(lpht_pkg::MODE_REMOVE, pick_key(), $urandom());
      else if (r < 95) send_item(lpht_pkg::MODE_SEARCH, pick_key(), $urandom());
      else             send_item(lpht_pkg::MODE_UNUSED, pick_key(), $urandom());
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int free_slot;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, wrap at last slot, duplicates, deleted marks
    send_item(lpht_pkg::MODE_SEARCH, 31'd0, 32'd0);          // search on empty table
    send_item(lpht_pkg::MODE_INSERT, 31'd0, 32'd0);
    send_item(lpht_pkg::MODE_INSERT, 31'h7fff_ffff, 32'hffff_ffff); // home is last slot
    send_item(lpht_pkg::MODE_INSERT, 31'd1023, 32'h5555_aaaa); // wraps past slot 0
    send_item(lpht_pkg::MODE_SEARCH, 31'h7fff_ffff, 32'd0);
    send_item(lpht_pkg::MODE_SEARCH, 31'd1023, 32'hffff_ffff);
    send_item(lpht_pkg::MODE_SEARCH, 31'd0, 32'd0);
    send_item(lpht_pkg::MODE_INSERT, 31'd5, 32'h1111_1111);
    send_item(lpht_pkg::MODE_INSERT, 31'd5, 32'h2222_2222);  // duplicate key
    send_item(lpht_pkg::MODE_INSERT, 31'd1029, 32'haaaa_5555); // same home as 5
    send_item(lpht_pkg::MODE_REMOVE, 31'd5, 32'd0);          // first copy goes
    send_item(lpht_pkg::MODE_SEARCH, 31'd5, 32'd0);          // second copy found
    send_item(lpht_pkg::MODE_SEARCH, 31'd1029, 32'd0);       // skips deleted mark
    send_item(lpht_pkg::MODE_REMOVE, 31'd77, 32'd0);         // absent key
    send_item(lpht_pkg::MODE_SEARCH, 31'd2053, 32'd0);       // miss past chain
    send_item(lpht_pkg::MODE_UNUSED, 31'd1029, 32'hffff_ffff); // ignored
    send_item(lpht_pkg::MODE_INSERT, 31'd6, 32'h3333_3333);  // probes past live slots to an empty one
    send_item(lpht_pkg::MODE_REMOVE, 31'd0, 32'd0);
    send_item(lpht_pkg::MODE_REMOVE, 31'h7fff_ffff, 32'd0);
    send_item(lpht_pkg::MODE_SEARCH, 31'd1023, 32'd0);

    random_phase(0, 0);
    random_phase(51, 0);
    random_phase(0, 51);
    random_phase(33, 33);

    // fill every remaining slot with a key whose home is that slot
    idle_pct  = 10;
    stall_pct = 10;
    while (sb.live < SLOTS) begin
      free_slot = 0;
      while (sb.marks[free_slot] == lpht_pkg::MARK_LIVE) free_slot++;
      send_item(lpht_pkg::MODE_INSERT,
                KEY_W'(free_slot + SLOTS * $urandom_range(0, 7)), $urandom());
    end
    // full table: refused insert, full-lap miss, then make room and refill
    send_item(lpht_pkg::MODE_INSERT, 31'd12, 32'hdead_beef);
    send_item(lpht_pkg::MODE_SEARCH, 31'h7fff_fff0, 32'd0);
    send_item(lpht_pkg::MODE_REMOVE, 31'h7fff_fff0, 32'd0);
    send_item(lpht_pkg::MODE_SEARCH, sb.keys[300], 32'd0);
    send_item(lpht_pkg::MODE_REMOVE, sb.keys[300], 32'd0);
    send_item(lpht_pkg::MODE_INSERT, 31'h7fff_ffff, 32'hffff_ffff); // probes a long way
    send_item(lpht_pkg::MODE_INSERT, 31'd3, 32'd1);
    send_item(lpht_pkg::MODE_SEARCH, 31'h7fff_ffff, 32'd0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[linear_probe_hash_table] OK");
    end else begin
      $display("[linear_probe_hash_table] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_ctrl.sv
src/lpht_dp.sv
src/linear_probe_hash_table.sv
tb/linear_probe_hash_table_tb.sv
